// ----- hdl/smbtq_pkg.sv -----
// Shared types and constants of the multi-bus SPI transfer queue.
// Depends on nothing; imported by the queue top level.
`default_nettype none

package smbtq_pkg;

   // Default sizing, handed to the top level parameters
   localparam int BUS_COUNT_DEF          = 10;
   localparam int RING_DEPTH_DEF         = 64;
   localparam int BYTES_PER_TRANSFER_DEF = 3;

   // Fixed field widths
   localparam int MASK_W   = 10;
   localparam int BUS_ID_W = 4;
   localparam int CS_W     = 2;
   localparam int DATA_W   = 24;
   localparam int TAG_W    = 16;
   localparam int BYTE_W   = 8;

   localparam logic [MASK_W-1:0] MASK_RESET = 10'd236;

   // Request codes
   typedef enum logic {
      REQ_ENQUEUE  = 1'b0,
      REQ_COMPLETE = 1'b1
   } req_kind_type;

   // Result codes
   typedef enum logic [1:0] {
      KIND_FRAME  = 2'd0,
      KIND_REPLY  = 2'd1,
      KIND_FULL   = 2'd2,
      KIND_ABSENT = 2'd3
   } kind_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ_HEAD,
      ST_READ_NEXT,
      ST_FRAMES,
      ST_REPLY
   } state_type;

endpackage

`default_nettype wire

// ----- hdl/smbtq_entry_ram.sv -----
// Entry store of all bus rings: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the queue top level.
`default_nettype none

module smbtq_entry_ram #(
   parameter int WIDTH  = 42,
   parameter int DEPTH  = 640,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data registered for the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/spi_multi_bus_transfer_queue.sv -----
// Multi-bus SPI transfer queue: accepts one request when busy is low, then runs a short sequence.
// Sequence: a reject beat in ST_CHECK; frame beats in ST_FRAMES, entered from ST_CHECK (enqueue)
// or via ST_READ_HEAD and ST_READ_NEXT (completion), one per cycle, the reply beat after them.
// One request at a time: busy stays high until its sequence is done; the entry RAM has a single
// read port and results leave at one beat per cycle; the receiver cannot stall.
// Reset: synchronous, clears heads, tails, busy flags and sequencer, loads the reset mask; entries stay unwritten.
`default_nettype none

module spi_multi_bus_transfer_queue
   import smbtq_pkg::*;
#(
   parameter int BUS_COUNT          = BUS_COUNT_DEF,
   parameter int RING_DEPTH         = RING_DEPTH_DEF,
   parameter int BYTES_PER_TRANSFER = BYTES_PER_TRANSFER_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request
   input  wire logic                start,
   output      logic                busy,
   input  wire logic                req_type,
   input  wire logic [BUS_ID_W-1:0] req_bus_id,
   input  wire logic [CS_W-1:0]     req_chip_select,
   input  wire logic [DATA_W-1:0]   req_tx_data,
   input  wire logic [TAG_W-1:0]    req_reply_tag,
   input  wire logic [DATA_W-1:0]   req_rx_data,
   // result
   output      logic                rsp_strobe,
   output      logic [1:0]          rsp_result_kind,
   output      logic [BUS_ID_W-1:0] rsp_out_bus,
   output      logic [CS_W-1:0]     rsp_out_chip_select,
   output      logic [BYTE_W-1:0]   rsp_tx_byte,
   output      logic                rsp_end_of_transfer,
   output      logic [DATA_W-1:0]   rsp_reply_data,
   output      logic [TAG_W-1:0]    rsp_out_tag,
   output      logic                rsp_last,
   // configuration
   input  wire logic                csr_wr_en,
   input  wire logic [MASK_W-1:0]   csr_wr_data
);

   localparam int BUS_W     = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;
   localparam int IDX_W     = $clog2(RING_DEPTH);
   localparam int RAM_DEPTH = BUS_COUNT * RING_DEPTH;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int FRAME_W   = BYTE_W * BYTES_PER_TRANSFER;
   localparam int ENTRY_W   = TAG_W + CS_W + FRAME_W;
   localparam int CNT_W     = (BYTES_PER_TRANSFER > 1) ? $clog2(BYTES_PER_TRANSFER) : 1;
   localparam int BUS_SPACE = 1 << BUS_ID_W;
   localparam int BUS_CMP_W = BUS_ID_W + 1;

   localparam logic [IDX_W-1:0]     IDX_LAST  = IDX_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0]     CNT_LAST  = CNT_W'(BYTES_PER_TRANSFER - 1);
   localparam logic [DATA_W-1:0]    RX_MASK   = DATA_W'((64'd1 << FRAME_W) - 64'd1);
   localparam logic [BUS_CMP_W-1:0] BUS_LIMIT = BUS_CMP_W'(BUS_COUNT);
   localparam logic [ADDR_W-1:0]    RING_SPAN = ADDR_W'(RING_DEPTH);

   // Sequencer and configuration
   state_type             state_ff, state_in;
   logic [MASK_W-1:0]     mask_ff;

   // Captured request
   req_kind_type          req_kind_ff;
   logic [BUS_ID_W-1:0]   bus_ff;
   logic [CS_W-1:0]       cs_ff;
   logic [DATA_W-1:0]     txd_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [DATA_W-1:0]     rxd_ff;

   // Per-bus ring pointers and busy flags
   logic [IDX_W-1:0]      head_ff [BUS_COUNT];
   logic [IDX_W-1:0]      tail_ff [BUS_COUNT];
   logic [BUS_COUNT-1:0]  bus_busy_ff;

   // Frame and reply working registers
   logic [FRAME_W-1:0]    frame_data_ff, frame_data_in;
   logic [CS_W-1:0]       frame_cs_ff, frame_cs_in;
   logic [CNT_W-1:0]      beat_cnt_ff, beat_cnt_in;
   logic                  reply_pend_ff, reply_pend_in;
   logic [TAG_W-1:0]      rtag_ff, rtag_in;

   // Decode of the addressed bus
   logic [BUS_W-1:0]      bus_idx;
   logic                  bus_ok;
   logic [BUS_SPACE-1:0]  mask_wide;
   logic                  bus_present;
   logic [IDX_W-1:0]      head_cur, tail_cur, head_next, tail_next;
   logic                  busy_cur;
   logic [ADDR_W-1:0]     bus_base, head_slot, tail_slot;

   // Control strobes
   logic                  tail_adv, head_adv, busy_set, busy_clr;
   logic                  ram_wr_en, ram_rd_en;
   logic [ENTRY_W-1:0]    ram_wr_data, ram_rd_data;
   kind_type              rsp_kind;
   logic                  frame_eot;

   assign bus_idx     = bus_ff[BUS_W-1:0];
   assign bus_ok      = {1'b0, bus_ff} < BUS_LIMIT;
   assign mask_wide   = BUS_SPACE'(mask_ff);
   assign bus_present = bus_ok && mask_wide[bus_ff];
   assign head_cur    = head_ff[bus_idx];
   assign tail_cur    = tail_ff[bus_idx];
   assign busy_cur    = bus_busy_ff[bus_idx];
   assign head_next   = (head_cur == IDX_LAST) ? '0 : head_cur + IDX_W'(1);
   assign tail_next   = (tail_cur == IDX_LAST) ? '0 : tail_cur + IDX_W'(1);
   assign bus_base    = ADDR_W'(bus_idx) * RING_SPAN;
   assign head_slot   = bus_base + ADDR_W'(head_cur);
   assign tail_slot   = bus_base + ADDR_W'(tail_cur);
   assign ram_wr_data = {tag_ff, cs_ff, FRAME_W'({8'd0, txd_ff})};
   assign frame_eot   = (beat_cnt_ff == CNT_LAST);
   assign busy        = (state_ff != ST_IDLE);
   assign rsp_result_kind = rsp_kind;

   smbtq_entry_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (RAM_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_slot),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_slot),
      .rd_data (ram_rd_data)
   );

   // Hold the enable mask
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_kind_ff <= req_kind_type'(req_type);
         bus_ff      <= req_bus_id;
         cs_ff       <= req_chip_select;
         txd_ff      <= req_tx_data;
         tag_ff      <= req_reply_tag;
         rxd_ff      <= req_rx_data;
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance ring pointers and busy flags of the addressed bus
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BUS_COUNT; b++) begin
            head_ff[b] <= '0;
            tail_ff[b] <= '0;
         end
         bus_busy_ff <= '0;
      end else begin
         if (tail_adv) begin
            tail_ff[bus_idx] <= tail_next;
         end
         if (head_adv) begin
            head_ff[bus_idx] <= head_next;
         end
         if (busy_set) begin
            bus_busy_ff[bus_idx] <= 1'b1;
         end else if (busy_clr) begin
            bus_busy_ff[bus_idx] <= 1'b0;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reply_pend_ff <= 1'b0;
         beat_cnt_ff   <= '0;
      end else begin
         reply_pend_ff <= reply_pend_in;
         beat_cnt_ff   <= beat_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_data_ff <= frame_data_in;
      frame_cs_ff   <= frame_cs_in;
      rtag_ff       <= rtag_in;
   end

   // Next state, result beat and control strobes
   always_comb begin
      state_in      = state_ff;
      frame_data_in = frame_data_ff;
      frame_cs_in   = frame_cs_ff;
      beat_cnt_in   = beat_cnt_ff;
      reply_pend_in = reply_pend_ff;
      rtag_in       = rtag_ff;
      tail_adv      = 1'b0;
      head_adv      = 1'b0;
      busy_set      = 1'b0;
      busy_clr      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      rsp_strobe          = 1'b0;
      rsp_kind            = KIND_FRAME;
      rsp_out_bus         = bus_ff;
      rsp_out_chip_select = '0;
      rsp_tx_byte         = '0;
      rsp_end_of_transfer = 1'b0;
      rsp_reply_data      = '0;
      rsp_out_tag         = '0;
      rsp_last            = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            state_in = ST_IDLE;
            unique case (req_kind_ff)
               REQ_ENQUEUE: begin
                  priority if (!bus_present) begin
                     rsp_strobe = 1'b1;
                     rsp_kind   = KIND_ABSENT;
                     rsp_last   = 1'b1;
                  end else if (tail_next == head_cur) begin
                     rsp_strobe = 1'b1;
                     rsp_kind   = KIND_FULL;
                     rsp_last   = 1'b1;
                  end else begin
                     ram_wr_en = 1'b1;
                     tail_adv  = 1'b1;
                     // An idle bus has an empty ring: start the new entry straight away
                     if (!busy_cur) begin
                        busy_set      = 1'b1;
                        frame_data_in = FRAME_W'({8'd0, txd_ff});
                        frame_cs_in   = cs_ff;
                        beat_cnt_in   = '0;
                        reply_pend_in = 1'b0;
                        state_in      = ST_FRAMES;
                     end
                  end
               end
               REQ_COMPLETE: begin
                  // Drop a completion on an out-of-range or idle bus
                  if (bus_ok && busy_cur && (head_cur != tail_cur)) begin
                     ram_rd_en = 1'b1;
                     head_adv  = 1'b1;
                     busy_clr  = 1'b1;
                     state_in  = ST_READ_HEAD;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end

         ST_READ_HEAD: begin
            // Popped entry's tag is here; fetch the new head if the ring is not empty
            rtag_in = ram_rd_data[ENTRY_W-1 -: TAG_W];
            if (head_cur != tail_cur) begin
               ram_rd_en     = 1'b1;
               busy_set      = 1'b1;
               reply_pend_in = 1'b1;
               state_in      = ST_READ_NEXT;
            end else begin
               state_in = ST_REPLY;
            end
         end

         ST_READ_NEXT: begin
            frame_data_in = ram_rd_data[FRAME_W-1:0];
            frame_cs_in   = ram_rd_data[FRAME_W +: CS_W];
            beat_cnt_in   = '0;
            state_in      = ST_FRAMES;
         end

         ST_FRAMES: begin
            rsp_strobe          = 1'b1;
            rsp_kind            = KIND_FRAME;
            rsp_out_chip_select = frame_cs_ff;
            rsp_tx_byte         = frame_data_ff[FRAME_W-1 -: BYTE_W];
            rsp_end_of_transfer = frame_eot;
            rsp_last            = frame_eot && !reply_pend_ff;
            frame_data_in       = frame_data_ff << BYTE_W;
            beat_cnt_in         = beat_cnt_ff + CNT_W'(1);
            if (frame_eot) begin
               state_in = reply_pend_ff ? ST_REPLY : ST_IDLE;
            end
         end

         ST_REPLY: begin
            rsp_strobe     = 1'b1;
            rsp_kind       = KIND_REPLY;
            rsp_reply_data = rxd_ff & RX_MASK;
            rsp_out_tag    = rtag_ff;
            rsp_last       = 1'b1;
            reply_pend_in  = 1'b0;
            state_in       = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // A result beat never appears while a request could be taken
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat while idle");

   // An accepted request always occupies the sequencer next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start the sequencer");

   // A frame beat that does not end the transfer is followed by another frame of the same bus
   a_frame_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_kind == KIND_FRAME && !rsp_end_of_transfer) |=>
      (rsp_strobe && rsp_result_kind == KIND_FRAME && $stable(rsp_out_bus)))
      else $error("frame run broken");

   // A final frame that is not the last beat is followed by the reply
   a_frame_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_end_of_transfer && !rsp_last) |=>
      (rsp_strobe && rsp_result_kind == KIND_REPLY && rsp_last))
      else $error("reply missing after restarted transfer");

   // Busy flags change only on a bus the sequencer addresses
   a_busy_bus_ok: assert property (@(posedge clock) disable iff (reset)
      (busy_set || busy_clr) |-> bus_ok)
      else $error("busy flag update on an absent bus");

endmodule

`default_nettype wire

// ----- sim/tb_spi_multi_bus_transfer_queue.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the multi-bus SPI transfer queue: directed and random requests,
// with a built-in queue predictor compared beat by beat. Depends on smbtq_pkg and the top level.

module tb_spi_multi_bus_transfer_queue;
   import smbtq_pkg::*;

   localparam int NBUS  = BUS_COUNT_DEF;
   localparam int DEPTH = RING_DEPTH_DEF;
   localparam int NBYTE = BYTES_PER_TRANSFER_DEF;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      kind_type            kind;
      logic [BUS_ID_W-1:0] bus;
      logic [CS_W-1:0]     cs;
      logic [BYTE_W-1:0]   data_byte;
      logic                eot;
      logic [DATA_W-1:0]   reply;
      logic [TAG_W-1:0]    tag;
      logic                last;
   } beat_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [BUS_ID_W-1:0] req_bus_id;
   logic [CS_W-1:0]     req_chip_select;
   logic [DATA_W-1:0]   req_tx_data;
   logic [TAG_W-1:0]    req_reply_tag;
   logic [DATA_W-1:0]   req_rx_data;
   logic                rsp_strobe;
   logic [1:0]          rsp_result_kind;
   logic [BUS_ID_W-1:0] rsp_out_bus;
   logic [CS_W-1:0]     rsp_out_chip_select;
   logic [BYTE_W-1:0]   rsp_tx_byte;
   logic                rsp_end_of_transfer;
   logic [DATA_W-1:0]   rsp_reply_data;
   logic [TAG_W-1:0]    rsp_out_tag;
   logic                rsp_last;
   logic                csr_wr_en;
   logic [MASK_W-1:0]   csr_wr_data;

   // Queue shadow state
   logic [DATA_W-1:0] ring_tx  [NBUS*DEPTH];
   logic [CS_W-1:0]   ring_cs  [NBUS*DEPTH];
   logic [TAG_W-1:0]  ring_tag [NBUS*DEPTH];
   int                q_head [NBUS];
   int                q_tail [NBUS];
   bit                bus_active [NBUS];
   logic [MASK_W-1:0] live_mask;

   beat_type pending_beats[$];
   int       mismatches;
   bit       no_gaps;
   bit       last_effective;

   spi_multi_bus_transfer_queue u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_bus_id          (req_bus_id),
      .req_chip_select     (req_chip_select),
      .req_tx_data         (req_tx_data),
      .req_reply_tag       (req_reply_tag),
      .req_rx_data         (req_rx_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_out_bus         (rsp_out_bus),
      .rsp_out_chip_select (rsp_out_chip_select),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_end_of_transfer (rsp_end_of_transfer),
      .rsp_reply_data      (rsp_reply_data),
      .rsp_out_tag         (rsp_out_tag),
      .rsp_last            (rsp_last),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Run limit, far above the slowest correct run
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   function automatic int next_slot(int i);
      return (i + 1 >= DEPTH) ? 0 : i + 1;
   endfunction

   function automatic beat_type make_beat(kind_type kind, int bus, logic [CS_W-1:0] cs,
                                          logic [BYTE_W-1:0] data_byte, logic eot,
                                          logic [DATA_W-1:0] reply, logic [TAG_W-1:0] tag);
      beat_type b;
      b.kind      = kind;
      b.bus       = BUS_ID_W'(bus);
      b.cs        = cs;
      b.data_byte = data_byte;
      b.eot       = eot;
      b.reply     = reply;
      b.tag       = tag;
      b.last      = 1'b0;
      return b;
   endfunction

   // Launch the head entry of an idle, non-empty bus: one frame beat per byte
   function automatic void launch_head(int bus);
      int          slot;
      int          sh;
      logic [31:0] word;
      if (bus_active[bus] || q_head[bus] == q_tail[bus])
         return;
      slot = bus * DEPTH + q_head[bus];
      word = 32'(ring_tx[slot]);
      bus_active[bus] = 1'b1;
      for (int i = 0; i < NBYTE; i++) begin
         sh = 8 * (NBYTE - 1 - i);
         pending_beats.push_back(make_beat(KIND_FRAME, bus, ring_cs[slot],
                                           BYTE_W'(word >> sh), (i == NBYTE - 1), '0, '0));
      end
   endfunction

   // Advance the shadow queues by one accepted request and queue its beats
   function automatic bit predict_request(req_kind_type kind, logic [BUS_ID_W-1:0] bus,
                                          logic [CS_W-1:0] cs, logic [DATA_W-1:0] txd,
                                          logic [TAG_W-1:0] tag, logic [DATA_W-1:0] rxd);
      int               b;
      int               nt;
      int               slot;
      int               first;
      bit               stored;
      logic [TAG_W-1:0] done_tag;
      logic [31:0]      dmask;
      b      = int'(bus);
      first  = pending_beats.size();
      stored = 1'b0;
      dmask  = 32'((64'd1 << (8 * NBYTE)) - 64'd1);
      if (kind == REQ_ENQUEUE) begin
         if (b >= NBUS || !live_mask[b]) begin
            pending_beats.push_back(make_beat(KIND_ABSENT, b, '0, '0, 1'b0, '0, '0));
         end else begin
            nt = next_slot(q_tail[b]);
            if (nt == q_head[b]) begin
               pending_beats.push_back(make_beat(KIND_FULL, b, '0, '0, 1'b0, '0, '0));
            end else begin
               slot = b * DEPTH + q_tail[b];
               ring_tx[slot]  = DATA_W'(32'(txd) & dmask);
               ring_cs[slot]  = cs;
               ring_tag[slot] = tag;
               q_tail[b]      = nt;
               stored         = 1'b1;
               launch_head(b);
            end
         end
      end else if (b < NBUS && bus_active[b] && q_head[b] != q_tail[b]) begin
         // Pop the head, start the next entry, then reply with the popped tag
         slot          = b * DEPTH + q_head[b];
         done_tag      = ring_tag[slot];
         q_head[b]     = next_slot(q_head[b]);
         bus_active[b] = 1'b0;
         launch_head(b);
         pending_beats.push_back(make_beat(KIND_REPLY, b, '0, '0, 1'b0,
                                           DATA_W'(32'(rxd) & dmask), done_tag));
      end
      if (pending_beats.size() > first)
         pending_beats[pending_beats.size() - 1].last = 1'b1;
      return stored || (pending_beats.size() > first);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch(name, got, want);
   endtask

   // Compare each result beat against the oldest expectation
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_beats.size() == 0) begin
            report_mismatch("beat with nothing expected", 32'(rsp_result_kind), 0);
         end else begin
            want = pending_beats.pop_front();
            check_field("result_kind", 32'(rsp_result_kind), 32'(want.kind));
            check_field("out_bus", 32'(rsp_out_bus), 32'(want.bus));
            check_field("out_chip_select", 32'(rsp_out_chip_select), 32'(want.cs));
            check_field("tx_byte", 32'(rsp_tx_byte), 32'(want.data_byte));
            check_field("end_of_transfer", 32'(rsp_end_of_transfer), 32'(want.eot));
            check_field("reply_data", 32'(rsp_reply_data), 32'(want.reply));
            check_field("out_tag", 32'(rsp_out_tag), 32'(want.tag));
            check_field("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // Send one request beat; start stays high when the next one follows at once
   task automatic send_item(req_kind_type kind, int bus, logic [CS_W-1:0] cs,
                            logic [DATA_W-1:0] txd, logic [TAG_W-1:0] tag,
                            logic [DATA_W-1:0] rxd);
      int gap;
      if ($urandom_range(0, 24) == 0)
         no_gaps = !no_gaps;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type        <= kind;
      req_bus_id      <= BUS_ID_W'(bus);
      req_chip_select <= cs;
      req_tx_data     <= txd;
      req_reply_tag   <= tag;
      req_rx_data     <= rxd;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      last_effective = predict_request(kind, BUS_ID_W'(bus), cs, txd, tag, rxd);
   endtask

   // Drop start, hold until every expected beat is in, then let the block go quiet
   task automatic settle(int extra);
      @(negedge clock);
      start <= 1'b0;
      while (pending_beats.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_mask(logic [MASK_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      live_mask = value;
   endtask

   // Reset mask: frames, stored entries, absent buses, pops and ignored completions
   task automatic test_basic_flow();
      send_item(REQ_ENQUEUE, 2, 2'd0, 24'h000000, 16'h0000, 24'hFFFFFF);
      send_item(REQ_ENQUEUE, 3, 2'd3, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
      send_item(REQ_ENQUEUE, 2, 2'd2, 24'h00A5C3, 16'h1234, 24'h000000);
      send_item(REQ_ENQUEUE, 0, 2'd1, 24'h123456, 16'h0001, 24'h000000);
      send_item(REQ_ENQUEUE, 15, 2'd3, 24'hABCDEF, 16'h8000, 24'h000000);
      send_item(REQ_ENQUEUE, 9, 2'd0, 24'h800001, 16'h7FFF, 24'h000000);
      send_item(REQ_COMPLETE, 2, 2'd0, 24'h000000, 16'h0000, 24'h123456);
      send_item(REQ_COMPLETE, 2, 2'd3, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
      send_item(REQ_COMPLETE, 2, 2'd0, 24'h000000, 16'h0000, 24'h55AA55);
      send_item(REQ_COMPLETE, 12, 2'd0, 24'h000000, 16'h0000, 24'h00FF00);
      send_item(REQ_COMPLETE, 0, 2'd0, 24'h000000, 16'h0000, 24'h0F0F0F);
      send_item(REQ_COMPLETE, 3, 2'd1, 24'h000000, 16'h0000, 24'h000000);
   endtask

   // Fill one ring to capacity, hit the full reject twice, then drain it
   task automatic test_ring_full();
      for (int i = 0; i < DEPTH - 1; i++)
         send_item(REQ_ENQUEUE, 9, CS_W'($urandom()), DATA_W'($urandom()),
                   TAG_W'($urandom()), DATA_W'($urandom()));
      send_item(REQ_ENQUEUE, 9, 2'd1, 24'hFEDCBA, 16'hBEEF, 24'h000000);
      send_item(REQ_ENQUEUE, 9, 2'd2, 24'h010203, 16'hCAFE, 24'h000000);
      for (int i = 0; i < DEPTH - 1; i++)
         send_item(REQ_COMPLETE, 9, CS_W'($urandom()), DATA_W'($urandom()),
                   TAG_W'($urandom()), DATA_W'($urandom()));
      send_item(REQ_COMPLETE, 9, 2'd0, 24'h000000, 16'h0000, 24'h111111);
   endtask

   // Completions still drain a bus whose mask bit was cleared after enqueue
   task automatic test_mask_after_enqueue();
      send_item(REQ_ENQUEUE, 4, 2'd1, 24'hC0FFEE, 16'h4444, 24'h000000);
      send_item(REQ_ENQUEUE, 4, 2'd2, 24'h0BADF0, 16'h5555, 24'h000000);
      settle(SETTLE_CYCLES);
      write_mask('0);
      send_item(REQ_COMPLETE, 4, 2'd0, 24'h000000, 16'h0000, 24'hA1B2C3);
      send_item(REQ_COMPLETE, 4, 2'd0, 24'h000000, 16'h0000, 24'hD4E5F6);
      send_item(REQ_ENQUEUE, 4, 2'd3, 24'h777777, 16'h6666, 24'h000000);
   endtask

   // Mostly enqueues to live buses and completions on active ones, some noise
   task automatic rand_request();
      int pick;
      int b;
      int active[$];
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         b = $urandom_range(0, NBUS - 1);
         for (int t = 0; t < 32 && live_mask != '0 && !live_mask[b]; t++)
            b = $urandom_range(0, NBUS - 1);
         send_item(REQ_ENQUEUE, b, CS_W'($urandom()), DATA_W'($urandom()),
                   TAG_W'($urandom()), DATA_W'($urandom()));
      end else if (pick < 88) begin
         foreach (bus_active[i])
            if (bus_active[i])
               active.push_back(i);
         b = (active.size() != 0) ? active[$urandom_range(0, active.size() - 1)]
                                  : $urandom_range(0, 15);
         send_item(REQ_COMPLETE, b, CS_W'($urandom()), DATA_W'($urandom()),
                   TAG_W'($urandom()), DATA_W'($urandom()));
      end else begin
         send_item(req_kind_type'($urandom_range(0, 1)), $urandom_range(0, 15),
                   CS_W'($urandom()), DATA_W'($urandom()), TAG_W'($urandom()),
                   DATA_W'($urandom()));
      end
   endtask

   task automatic test_random_traffic(int count);
      int done;
      done = 0;
      while (done < count) begin
         rand_request();
         if (last_effective)
            done++;
         // Now and then hold the sender until the queue of beats runs dry
         if ($urandom_range(0, 59) == 0)
            settle(0);
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = 1'b0;
      req_bus_id      = '0;
      req_chip_select = '0;
      req_tx_data     = '0;
      req_reply_tag   = '0;
      req_rx_data     = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      mismatches      = 0;
      no_gaps         = 1'b0;
      last_effective  = 1'b0;
      live_mask       = MASK_RESET;
      foreach (q_head[i]) begin
         q_head[i]     = 0;
         q_tail[i]     = 0;
         bus_active[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_flow();
      settle(SETTLE_CYCLES);
      write_mask(10'h3FF);
      test_ring_full();
      test_mask_after_enqueue();
      settle(SETTLE_CYCLES);
      write_mask(10'h3FF);
      test_random_traffic(80);
      settle(SETTLE_CYCLES);
      write_mask(MASK_W'($urandom()));
      test_random_traffic(60);
      settle(SETTLE_CYCLES);
      write_mask('0);
      test_random_traffic(15);
      settle(SETTLE_CYCLES);
      write_mask(MASK_RESET);
      test_random_traffic(60);
      settle(SETTLE_CYCLES);

      if (mismatches == 0 && pending_beats.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/smbtq_pkg.sv
hdl/smbtq_entry_ram.sv
hdl/spi_multi_bus_transfer_queue.sv
sim/tb_spi_multi_bus_transfer_queue.sv
